[sv/mandelbrot_pixel_colour_top_defines.svh]
// assertion macros shared by the mandelbrot pixel colour rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef MANDELBROT_PIXEL_COLOUR_TOP_DEFINES_SVH
`define MANDELBROT_PIXEL_COLOUR_TOP_DEFINES_SVH

// property checked at every rising edge outside reset
`define MPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define MPC_ASSERT_NEVER(label, cond, msg) \
  `MPC_ASSERT(label, !(cond), msg)

`endif

[sv/mpc_pkg.sv]
// types, constants and helpers for the mandelbrot pixel colour block
// no dependencies
package mpc_pkg;

  // field widths
  localparam int PIX_X_W    = 9;
  localparam int PIX_Y_W    = 8;
  localparam int ITER_W     = 7;
  localparam int COLOUR_W   = 16;
  localparam int Z_W        = 32;
  localparam int STEP_W     = 28;
  localparam int PROD_W     = 64;

  // parameter defaults
  localparam int X_BITS_DEF    = 9;
  localparam int Y_BITS_DEF    = 8;
  localparam int FRAC_BITS_DEF = 28;

  localparam int QUEUE_DEPTH = 2;

  // colour division: quotient below 32, dividend count*31 fits 12 bits
  localparam int QUO_W       = 5;
  localparam int DIVIDEND_W  = 12;
  localparam int GREEN_LSB   = 6;
  localparam logic [DIVIDEND_W-1:0] GREEN_SCALE = 12'd31;

  localparam logic [COLOUR_W-1:0] COLOUR_BLUE  = 16'h001F;
  localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 16'h0000;
  localparam logic [PROD_W-1:0]   ESCAPE_RADIUS_SQ = 64'd4;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [ITER_W-1:0]       MAX_ITER_RST = 7'd20;
  localparam logic signed [Z_W-1:0]   RE_LEFT_RST  = -32'sd706409095;
  localparam logic signed [Z_W-1:0]   IM_TOP_RST   = -32'sd317884093;
  localparam logic [STEP_W-1:0]       STEP_RST     = 28'd2825636;

  typedef enum logic [1:0] {
    REG_MAX_ITER = 2'd0,
    REG_RE_LEFT  = 2'd1,
    REG_IM_TOP   = 2'd2,
    REG_STEP     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_X_W-1:0]  out_x;
    logic [PIX_Y_W-1:0]  out_y;
    logic [ITER_W-1:0]   iteration_count;
    logic [COLOUR_W-1:0] colour;
  } pixel_out_t;

  // one point waiting for the iteration engine
  typedef struct packed {
    logic [PIX_X_W-1:0]     out_x;
    logic [PIX_Y_W-1:0]     out_y;
    logic signed [Z_W-1:0]  c_re;
    logic signed [Z_W-1:0]  c_im;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD,
    BK_DIV,
    BK_DONE
  } back_state_e;

  localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

  // clamp to the signed 32-bit range
  function automatic logic signed [Z_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Z_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Z_W-1:0];
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/mpc_front.sv]
// front end: takes pixel words and forms the point c for each
// depends on mpc_pkg
module mpc_front #(
  parameter int X_BITS = mpc_pkg::X_BITS_DEF,
  parameter int Y_BITS = mpc_pkg::Y_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpc_pkg::pixel_in_t  in_word_i,
  input  logic signed [31:0]  re_at_left_i,
  input  logic signed [31:0]  im_at_top_i,
  input  logic [27:0]         pixel_step_i,
  input  mpc_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output mpc_pkg::point_t     point_o
);
  import mpc_pkg::*;

  localparam int XPROD_W = X_BITS + STEP_W;
  localparam int YPROD_W = Y_BITS + STEP_W;

  logic              hold_valid_q, hold_valid_d;
  logic [X_BITS-1:0] px_q;
  logic [Y_BITS-1:0] py_q;
  logic              accept;

  logic [XPROD_W-1:0]        x_prod;
  logic [YPROD_W-1:0]        y_prod;
  logic signed [PROD_W-1:0]  re_sum;
  logic signed [PROD_W-1:0]  im_sum;

  assign in_stall_o = hold_valid_q && q_status_i.full;
  assign push_o     = hold_valid_q && !q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (push_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= X_BITS'(in_word_i.pixel_x);
      py_q <= Y_BITS'(in_word_i.pixel_y);
    end
  end

  // c = corner + pixel * step, clamped
  always_comb begin
    x_prod = XPROD_W'(px_q) * XPROD_W'(pixel_step_i);
    y_prod = YPROD_W'(py_q) * YPROD_W'(pixel_step_i);
    re_sum = PROD_W'(re_at_left_i) + $signed(PROD_W'(x_prod));
    im_sum = PROD_W'(im_at_top_i) + $signed(PROD_W'(y_prod));
    point_o.out_x = PIX_X_W'(px_q);
    point_o.out_y = PIX_Y_W'(py_q);
    point_o.c_re  = sat32(re_sum);
    point_o.c_im  = sat32(im_sum);
  end

endmodule

[sv/mpc_queue.sv]
// short first-in first-out queue of points between front and back
// depends on mpc_pkg and the assertion macro header
`include "mandelbrot_pixel_colour_top_defines.svh"

module mpc_queue #(
  parameter int DEPTH = mpc_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mpc_pkg::point_t     point_i,
  input  logic                pop_i,
  output mpc_pkg::point_t     head_o,
  output mpc_pkg::q_status_t  status_o
);
  import mpc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  point_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0]  level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= point_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (level_q == LVL_W'(DEPTH));
  assign status_o.empty = (level_q == '0);

  `MPC_ASSERT(q_no_push_when_full, push_i |-> !status_o.full, "push into full queue")
  `MPC_ASSERT_NEVER(q_no_pop_when_empty, pop_i && status_o.empty, "pop from empty queue")

endmodule

[sv/mpc_back.sv]
// back end: escape-time iteration and colour division for one point at a time
// depends on mpc_pkg and the assertion macro header
`include "mandelbrot_pixel_colour_top_defines.svh"

module mpc_back #(
  parameter int FRAC_BITS = mpc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          max_iterations_i,
  input  mpc_pkg::q_status_t  q_status_i,
  input  mpc_pkg::point_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpc_pkg::pixel_out_t out_word_o
);
  import mpc_pkg::*;

  localparam logic [PROD_W-1:0] ESC_LIMIT = ESCAPE_RADIUS_SQ << (2 * FRAC_BITS);
  localparam int IDX_W = $clog2(QUO_W);

  back_state_e state_q, state_d;

  logic [PIX_X_W-1:0]       x_q, x_d;
  logic [PIX_Y_W-1:0]       y_q, y_d;
  logic signed [Z_W-1:0]    c_re_q, c_re_d, c_im_q, c_im_d;
  logic signed [Z_W-1:0]    z_re_q, z_re_d, z_im_q, z_im_d;
  logic signed [PROD_W-1:0] rr_q, rr_d, ii_q, ii_d, ri_q, ri_d;
  logic [ITER_W-1:0]        lim_q, lim_d, count_q, count_d;
  logic [DIVIDEND_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     out_valid_q, out_valid_d;
  pixel_out_t               out_q, out_d;

  logic [PROD_W-1:0]        mag;
  logic signed [PROD_W-1:0] diff;
  logic signed [Z_W-1:0]    re_next, im_next;
  logic                     stop;
  logic [DIVIDEND_W-1:0]    trial;
  logic                     out_free;
  logic [COLOUR_W-1:0]      colour;

  always_comb begin
    mag      = $unsigned(rr_q) + $unsigned(ii_q);
    stop     = (count_q >= lim_q) || (mag > ESC_LIMIT);
    diff     = rr_q - ii_q;
    re_next  = sat32((diff >>> FRAC_BITS) + PROD_W'(c_re_q));
    im_next  = sat32((ri_q >>> (FRAC_BITS - 1)) + PROD_W'(c_im_q));
    trial    = DIVIDEND_W'(lim_q) << idx_q;
    out_free = !out_valid_q || !out_stall_i;
    colour   = (count_q == lim_q) ? COLOUR_BLACK
                                  : (COLOUR_BLUE | (COLOUR_W'(quo_q) << GREEN_LSB));
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    c_re_d      = c_re_q;
    c_im_d      = c_im_q;
    z_re_d      = z_re_q;
    z_im_d      = z_im_q;
    rr_d        = rr_q;
    ii_d        = ii_q;
    ri_d        = ri_q;
    lim_d       = lim_q;
    count_d     = count_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    idx_d       = idx_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          x_d     = head_i.out_x;
          y_d     = head_i.out_y;
          c_re_d  = head_i.c_re;
          c_im_d  = head_i.c_im;
          lim_d   = max_iterations_i;
          z_re_d  = '0;
          z_im_d  = '0;
          count_d = '0;
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        rr_d    = z_re_q * z_re_q;
        ii_d    = z_im_q * z_im_q;
        ri_d    = z_re_q * z_im_q;
        state_d = BK_UPD;
      end
      BK_UPD: begin
        if (stop) begin
          if (count_q == lim_q) begin
            state_d = BK_DONE;
          end else begin
            rem_d   = DIVIDEND_W'(count_q) * GREEN_SCALE;
            quo_d   = '0;
            idx_d   = IDX_W'(QUO_W - 1);
            state_d = BK_DIV;
          end
        end else begin
          z_re_d  = re_next;
          z_im_d  = im_next;
          count_d = count_q + 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_DIV: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        if (idx_q == '0) begin
          state_d = BK_DONE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_d.out_x           = x_q;
          out_d.out_y           = y_q;
          out_d.iteration_count = count_q;
          out_d.colour          = colour;
          out_valid_d           = 1'b1;
          state_d               = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    c_re_q  <= c_re_d;
    c_im_q  <= c_im_d;
    z_re_q  <= z_re_d;
    z_im_q  <= z_im_d;
    rr_q    <= rr_d;
    ii_q    <= ii_d;
    ri_q    <= ri_d;
    lim_q   <= lim_d;
    count_q <= count_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    idx_q   <= idx_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `MPC_ASSERT(bk_count_within_limit, (state_q != BK_IDLE) |-> (count_q <= lim_q), "count above limit")
  `MPC_ASSERT(bk_count_steps_by_one, (state_q == BK_UPD && !stop) |=> (count_q == $past(count_q) + 1'b1), "count did not step")
  `MPC_ASSERT(bk_black_only_at_limit, (state_q == BK_DONE && out_free) |-> ((colour == COLOUR_BLACK) == (count_q == lim_q)), "black colour mismatch")

endmodule

[sv/mandelbrot_pixel_colour_top.sv]
// top level of the mandelbrot escape-time pixel colouring block
// depends on mpc_pkg, mpc_front, mpc_queue and mpc_back
//
//   channel   direction  handshake                     word
//   in        input      in_valid_i / in_stall_o       pixel_in_t  (pixel_x, pixel_y)
//   out       output     out_valid_o / out_stall_i     pixel_out_t (x, y, count, colour)
//   config    input      apb: psel penable pwrite ...  32-bit registers at 4*index
//
// a pixel passes through a load state, a multiply and an update state per iteration,
// a final escape test, the colour division when it stops short of the limit, and a
// hand-over state; the loop through the three 32x32 multipliers sets the rate
// the front forms c one pixel a cycle unless the full queue stalls it, and a
// two-word queue holds points for the engine
// reset returns the view registers to their defaults; there is no clearing pass
// a stalled output holds its word while the engine carries on with the next pixel
module mandelbrot_pixel_colour_top #(
  parameter int X_BITS    = mpc_pkg::X_BITS_DEF,
  parameter int Y_BITS    = mpc_pkg::Y_BITS_DEF,
  parameter int FRAC_BITS = mpc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpc_pkg::pixel_in_t  in_word_i,
  // coloured pixel output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpc_pkg::pixel_out_t out_word_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mpc_pkg::*;

  // view registers
  logic [ITER_W-1:0]      max_iter_q;
  logic signed [Z_W-1:0]  re_left_q;
  logic signed [Z_W-1:0]  im_top_q;
  logic [STEP_W-1:0]      step_q;

  logic      cfg_write;
  cfg_reg_e  cfg_sel;

  // front to queue to back
  logic       push;
  logic       pop;
  point_t     point_in;
  point_t     point_head;
  q_status_t  q_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      re_left_q  <= RE_LEFT_RST;
      im_top_q   <= IM_TOP_RST;
      step_q     <= STEP_RST;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_MAX_ITER: max_iter_q <= pwdata[ITER_W-1:0];
        REG_RE_LEFT:  re_left_q  <= $signed(pwdata);
        REG_IM_TOP:   im_top_q   <= $signed(pwdata);
        REG_STEP:     step_q     <= pwdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back, narrow registers zero-extended
  always_comb begin
    case (cfg_sel)
      REG_MAX_ITER: prdata = APB_DATA_W'(max_iter_q);
      REG_RE_LEFT:  prdata = re_left_q;
      REG_IM_TOP:   prdata = im_top_q;
      REG_STEP:     prdata = APB_DATA_W'(step_q);
      default:      prdata = '0;
    endcase
  end

  // forms c from the pixel and the view
  mpc_front #(
    .X_BITS (X_BITS),
    .Y_BITS (Y_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .re_at_left_i (re_left_q),
    .im_at_top_i  (im_top_q),
    .pixel_step_i (step_q),
    .q_status_i   (q_status),
    .push_o       (push),
    .point_o      (point_in)
  );

  // decouples the front from the long iteration
  mpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .point_i  (point_in),
    .pop_i    (pop),
    .head_o   (point_head),
    .status_o (q_status)
  );

  // escape-time loop, colour division and output register
  mpc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .max_iterations_i (max_iter_q),
    .q_status_i       (q_status),
    .head_i           (point_head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_word_o       (out_word_o)
  );

endmodule

[verif/tb_mandelbrot_pixel_colour_top.sv]
// self-checking testbench for the mandelbrot pixel colour block
// depends on mpc_pkg and mandelbrot_pixel_colour_top; predicts every word in the bench
module tb_mandelbrot_pixel_colour_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpc_pkg::*;

  // escape test bound: radius squared in the scale of a full product
  localparam longint unsigned ESCAPE_LIMIT = ESCAPE_RADIUS_SQ << (2 * FRAC_BITS_DEF);
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // a few points of the plane in q4.28
  localparam logic [31:0] Q_MINUS_TWO   = -32'sd536870912;
  localparam logic [31:0] Q_MINUS_2P5   = -32'sd671088640;
  localparam logic [31:0] Q_MINUS_1P25  = -32'sd335544320;
  localparam logic [31:0] Q_MINUS_0P75  = -32'sd201326592;
  localparam logic [31:0] Q_0P1         = 32'sd26843546;
  localparam int unsigned Q_3P0         = 805306368;
  localparam int unsigned Q_2P5         = 671088640;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PIXELS_PER_VIEW = 125;

  logic       clk_i;
  logic       rst_ni = 1'b0;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  pixel_in_t  in_word_i = '0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  pixel_out_t out_word_o;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the view registers
  logic [ITER_W-1:0]       limit_reg   = MAX_ITER_RST;
  logic signed [Z_W-1:0]   re_left_reg = RE_LEFT_RST;
  logic signed [Z_W-1:0]   im_top_reg  = IM_TOP_RST;
  logic [STEP_W-1:0]       step_reg    = STEP_RST;

  // coloured pixels still owed by the block, oldest first
  pixel_out_t  owed_pixels_q[$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  mandelbrot_pixel_colour_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // clamp to the signed 32-bit range of the q4.28 registers
  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // escape-time count and colour of one pixel under the current view
  function automatic pixel_out_t escape_pixel(input pixel_in_t p);
    longint            c_re, c_im, z_re, z_im, rr, ii, ri;
    longint unsigned   mag;
    int unsigned       n, lim;
    pixel_out_t        r;
    lim  = int'(limit_reg);
    c_re = clamp_q428(longint'(re_left_reg) + longint'(p.pixel_x) * longint'(step_reg));
    c_im = clamp_q428(longint'(im_top_reg) + longint'(p.pixel_y) * longint'(step_reg));
    z_re = 0;
    z_im = 0;
    n    = 0;
    while (n < lim) begin
      rr  = z_re * z_re;
      ii  = z_im * z_im;
      ri  = z_re * z_im;
      mag = $unsigned(rr) + $unsigned(ii);
      if (mag > ESCAPE_LIMIT) begin
        break;
      end
      // arithmetic shifts round toward minus infinity; the doubling is folded into the shift
      z_re = clamp_q428(((rr - ii) >>> FRAC_BITS_DEF) + c_re);
      z_im = clamp_q428((ri >>> (FRAC_BITS_DEF - 1)) + c_im);
      n++;
    end
    r.out_x           = p.pixel_x;
    r.out_y           = p.pixel_y;
    r.iteration_count = n[ITER_W-1:0];
    if (n == lim) begin
      r.colour = COLOUR_BLACK;
    end else begin
      // green channel scales the count over the limit, blue always full
      r.colour = COLOUR_BLUE | 16'(((n * int'(GREEN_SCALE)) / lim) << GREEN_LSB);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: check every word taken and stall in runs of random length
  // ---------------------------------------------------------------------------

  int unsigned stall_run = 0;

  always @(posedge clk_i) begin : colour_checker
    pixel_out_t want;
    int unsigned pick;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_pixels_q.size() == 0) begin
        $error("unexpected word x=%0d y=%0d with nothing owed",
               out_word_o.out_x, out_word_o.out_y);
        fail_count++;
      end else begin
        want = owed_pixels_q.pop_front();
        if (out_word_o.out_x !== want.out_x) begin
          $error("out_x expected %0d got %0d", want.out_x, out_word_o.out_x);
          fail_count++;
        end
        if (out_word_o.out_y !== want.out_y) begin
          $error("out_y expected %0d got %0d", want.out_y, out_word_o.out_y);
          fail_count++;
        end
        if (out_word_o.iteration_count !== want.iteration_count) begin
          $error("iteration_count expected %0d got %0d (pixel %0d,%0d)",
                 want.iteration_count, out_word_o.iteration_count, want.out_x, want.out_y);
          fail_count++;
        end
        if (out_word_o.colour !== want.colour) begin
          $error("colour expected %04h got %04h (pixel %0d,%0d)",
                 want.colour, out_word_o.colour, want.out_x, want.out_y);
          fail_count++;
        end
      end
    end
    // stall pattern: long free runs, short blips and the odd long hold
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(1, 40);
      end else if (pick < 8) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(3, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side and register port
  // ---------------------------------------------------------------------------

  // offer one pixel, hold it until taken, then maybe close the burst with a gap
  task automatic send_pixel(input pixel_in_t w);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    owed_pixels_q.push_back(escape_pixel(w));
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_xy(input int unsigned x, input int unsigned y);
    pixel_in_t w;
    w.pixel_x = x[PIX_X_W-1:0];
    w.pixel_y = y[PIX_Y_W-1:0];
    send_pixel(w);
  endtask

  // stop offering and wait until every owed word has come out
  task automatic wait_pixels_drained();
    in_valid_i <= 1'b0;
    while (owed_pixels_q.size() != 0) @(posedge clk_i);
  endtask

  // one apb transfer: setup, access, then idle with psel dropped
  task automatic apb_transfer(input logic wr, input cfg_reg_e idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // read a register and compare with the bench copy
  task automatic check_readback(input cfg_reg_e idx);
    logic [31:0] got, want;
    apb_transfer(1'b0, idx, '0, got);
    case (idx)
      REG_MAX_ITER: want = 32'(limit_reg);
      REG_RE_LEFT:  want = re_left_reg;
      REG_IM_TOP:   want = im_top_reg;
      default:      want = 32'(step_reg);
    endcase
    if (got !== want) begin
      $error("register %s readback expected %08h got %08h", idx.name(), want, got);
      fail_count++;
    end
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, idx, value, unused);
    case (idx)
      REG_MAX_ITER: limit_reg   = value[ITER_W-1:0];
      REG_RE_LEFT:  re_left_reg = value;
      REG_IM_TOP:   im_top_reg  = value;
      default:      step_reg    = value[STEP_W-1:0];
    endcase
    check_readback(idx);
  endtask

  // only called with the block idle
  task automatic set_view(input logic [31:0] lim, input logic [31:0] re,
                          input logic [31:0] im, input logic [31:0] stp);
    set_reg(REG_MAX_ITER, lim);
    set_reg(REG_RE_LEFT, re);
    set_reg(REG_IM_TOP, im);
    set_reg(REG_STEP, stp);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of the view and a handful of pixels across the default picture
  task automatic test_reset_view();
    check_readback(REG_MAX_ITER);
    check_readback(REG_RE_LEFT);
    check_readback(REG_IM_TOP);
    check_readback(REG_STEP);
    send_xy(0, 0);
    send_xy(511, 255);
    send_xy(511, 0);
    send_xy(0, 255);
    send_xy(250, 112);  // close to the origin, stays inside
    send_xy(200, 100);
    send_xy(300, 50);
    send_xy(100, 200);
    wait_pixels_drained();
  endtask

  // zero limit gives count 0 and black, one and the widest limit at the edges
  task automatic test_limit_extremes();
    int unsigned lims[3] = '{0, 1, 127};
    foreach (lims[i]) begin
      set_reg(REG_MAX_ITER, lims[i]);
      send_xy(250, 112);
      send_xy(0, 0);
      send_xy($urandom_range(0, 511), $urandom_range(0, 255));
      wait_pixels_drained();
    end
  endtask

  // c clamped at the range edges, a zero step, and the point sitting on the escape circle
  task automatic test_coordinate_saturation();
    set_view(20, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0FFF_FFFF);
    send_xy(511, 255);
    send_xy(0, 0);
    send_xy(1, 0);
    wait_pixels_drained();
    // c = 0 everywhere: never escapes
    set_view(99, 32'h0, 32'h0, 32'h0);
    send_xy(511, 255);
    wait_pixels_drained();
    // c = -2 bounces to magnitude exactly 4, which still counts as inside
    set_reg(REG_RE_LEFT, Q_MINUS_TWO);
    send_xy(37, 201);
    wait_pixels_drained();
    set_view(10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0FFF_FFFF);
    send_xy(0, 0);
    send_xy(511, 255);
    wait_pixels_drained();
  endtask

  // random pixels over a series of views, mostly well-placed ones
  task automatic test_random_views();
    logic [31:0] lim, re, im, stp;
    int unsigned x, y;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          // default picture, deep limit
          lim = 99;
          re  = RE_LEFT_RST;
          im  = IM_TOP_RST;
          stp = 32'(STEP_RST);
        end
        5: begin
          // tight zoom on the boundary near the neck of the set, widest limit
          lim = 127;
          re  = Q_MINUS_0P75 + $urandom_range(0, 1 << 20);
          im  = Q_0P1 + $urandom_range(0, 1 << 20);
          stp = $urandom_range(0, 4096);
        end
        6, 7: begin
          // anything the registers hold, upper unused bits included
          lim = $urandom();
          re  = $urandom();
          im  = $urandom();
          stp = $urandom();
        end
        default: begin
          lim = (phase == 1) ? 10 : $urandom_range(10, 99);
          re  = Q_MINUS_2P5 + $urandom_range(0, Q_3P0);
          im  = Q_MINUS_1P25 + $urandom_range(0, Q_2P5);
          stp = $urandom_range(1, 1 << 21);
        end
      endcase
      set_view(lim, re, im, stp);
      for (int unsigned k = 0; k < PIXELS_PER_VIEW; k++) begin
        // hold off once until the block has emptied completely
        if (phase == 3 && k == PIXELS_PER_VIEW / 2) begin
          wait_pixels_drained();
        end
        x = $urandom_range(0, 511);
        y = $urandom_range(0, 255);
        if ($urandom_range(0, 15) == 0) begin
          x = ($urandom_range(0, 1) != 0) ? 511 : 0;
          y = ($urandom_range(0, 1) != 0) ? 255 : 0;
        end
        send_xy(x, y);
      end
      wait_pixels_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_view();
    test_limit_extremes();
    test_coordinate_saturation();
    test_random_views();

    wait_pixels_drained();
    // watch for stray words
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/mpc_pkg.sv
sv/mpc_front.sv
sv/mpc_queue.sv
sv/mpc_back.sv
sv/mandelbrot_pixel_colour_top.sv
verif/tb_mandelbrot_pixel_colour_top.sv
